[rtl/wsdf_pkg.sv]
// Shared types and constants for the websocket frame deframer.
// No dependencies; imported by websocket_frame_deframer.
package wsdf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned HdrCntW  = 4;

  localparam logic [ByteW-1:0]   MaskBit   = 8'h80;
  localparam logic [ByteW-1:0]   Len7Mask  = 8'h7F;
  localparam logic [6:0]         Len16Code = 7'd126;
  localparam logic [6:0]         Len64Code = 7'd127;
  localparam logic [HdrCntW-1:0] Ext16Cnt  = 4'd2;
  localparam logic [HdrCntW-1:0] Ext64Cnt  = 4'd8;
  localparam logic [HdrCntW-1:0] KeyCnt    = 4'd4;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             chunk_end;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             byte_valid;
    logic             frame_end;
    logic             status;
  } out_word_t;

endpackage

[rtl/websocket_frame_deframer.sv]
// Websocket frame deframer: header decode, length count, payload unmasking.
// Depends on wsdf_pkg for the word types and header constants.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) carries one received
//   byte per word plus a chunk_end flag on the last byte of a receive chunk.
//   Every chunk starts a new frame. The first header byte is skipped, the
//   second gives the mask bit and 7-bit length, then an optional 16- or 64-bit
//   big-endian extended length and an optional 4-byte masking key follow.
//   Output channel (out_valid_o / out_ready_i / out_word_o) carries zero or
//   one word per input byte: an unmasked payload byte, an empty-frame marker
//   (frame_end with no byte), or a short-frame status when the chunk ends
//   before the frame is complete. Bytes after a complete frame give nothing.
//   Results are registered: the output register takes one when its byte is
//   accepted, or the skid entry does if the output is held. Throughput: one
//   byte per cycle while the skid entry is empty, set by the combinational
//   header and length update between parser state and output registers.
//   Stall: an output register plus one skid entry decouple the sides;
//   in_ready_o drops only while the skid entry is occupied.
//   Reset: parser returns to expecting the first header byte, both output
//   entries empty.
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhKey     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhDrain   = 3'd5;

  // parser state
  logic [2:0]         phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]    left_q, left_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [1:0]         pos_q, pos_d;
  logic               masked_q, masked_d;

  // output register and skid entry
  logic      out_vld_q, skid_vld_q;
  out_word_t out_q, skid_q;

  logic      in_fire, out_fire;
  logic      res_vld;
  out_word_t res;

  logic [6:0]       len7;
  logic [ByteW-1:0] key_byte;
  logic             done;

  assign in_ready_o = !skid_vld_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  assign len7     = 7'(in_word_i.rx_byte & Len7Mask);
  // key byte (pos mod 4), first key byte sits in the top byte
  assign key_byte = masked_q ? key_q[{~pos_q, 3'b000} +: ByteW] : '0;

  // Decode one byte: next parser state and an optional result word.
  always_comb begin
    phase_d  = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    left_d   = left_q;
    key_d    = key_q;
    pos_d    = pos_q;
    masked_d = masked_q;
    done     = 1'b0;
    res_vld  = 1'b0;
    res      = '0;

    unique case (phase_q)
      PhHdr0: begin
        phase_d = PhHdr1;
      end
      PhHdr1: begin
        masked_d = (in_word_i.rx_byte & MaskBit) != '0;
        key_d    = '0;
        pos_d    = '0;
        left_d   = '0;
        priority if (len7 == Len16Code) begin
          hdr_cnt_d = Ext16Cnt;
          phase_d   = PhExtLen;
        end else if (len7 == Len64Code) begin
          hdr_cnt_d = Ext64Cnt;
          phase_d   = PhExtLen;
        end else begin
          left_d = LenW'(len7);
          if (masked_d) begin
            hdr_cnt_d = KeyCnt;
            phase_d   = PhKey;
          end else if (len7 == '0) begin
            phase_d = PhDrain;
            done    = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhExtLen: begin
        left_d    = {left_q[LenW-ByteW-1:0], in_word_i.rx_byte};
        hdr_cnt_d = hdr_cnt_q - 1'b1;
        if (hdr_cnt_d == '0) begin
          if (masked_q) begin
            hdr_cnt_d = KeyCnt;
            phase_d   = PhKey;
          end else if (left_d == '0) begin
            phase_d = PhDrain;
            done    = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhKey: begin
        key_d     = {key_q[KeyW-ByteW-1:0], in_word_i.rx_byte};
        hdr_cnt_d = hdr_cnt_q - 1'b1;
        if (hdr_cnt_d == '0) begin
          if (left_q == '0) begin
            phase_d = PhDrain;
            done    = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        pos_d                = pos_q + 1'b1;
        left_d               = left_q - 1'b1;
        res_vld              = 1'b1;
        res.payload_byte     = in_word_i.rx_byte ^ key_byte;
        res.byte_valid       = 1'b1;
        if (left_d == '0) begin
          phase_d       = PhDrain;
          res.frame_end = 1'b1;
        end else begin
          res.frame_end = in_word_i.chunk_end;
          res.status    = in_word_i.chunk_end;
        end
      end
      default: begin
        // drain: drop bytes until the chunk ends
      end
    endcase

    if (done) begin
      res_vld       = 1'b1;
      res.frame_end = 1'b1;
    end else if (in_word_i.chunk_end && !res_vld && phase_d != PhDrain) begin
      // chunk ended inside the header: report a short frame
      res_vld       = 1'b1;
      res.frame_end = 1'b1;
      res.status    = 1'b1;
    end

    if (in_word_i.chunk_end) begin
      phase_d   = PhHdr0;
      hdr_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      hdr_cnt_q <= '0;
      left_q   <= '0;
      key_q    <= '0;
      pos_q    <= '0;
      masked_q <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      left_q   <= left_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      masked_q <= masked_d;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire && res_vld) begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_vld) begin
      if (!out_vld_q || out_ready_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_empty_word_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.byte_valid) |-> out_q.frame_end)
    else $error("word without payload byte does not end a frame");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status) |-> out_q.frame_end)
    else $error("short-frame status without frame end");

  a_chunk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.chunk_end) |=> (phase_q == PhHdr0))
    else $error("chunk end did not restart the parser");

  a_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhKey) |-> (hdr_cnt_q != '0 && hdr_cnt_q <= KeyCnt))
    else $error("key byte count out of range");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer: directed and random frame traffic,
// scored word by word against an in-bench frame predictor. Needs wsdf_pkg.
module tb;
  import wsdf_pkg::*;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    RX_HDR0, RX_HDR1, RX_EXTLEN, RX_KEY, RX_PAYLOAD, RX_DRAIN
  } rx_phase_e;

  // Length encodings used when building frames.
  localparam int unsigned LenShort = 0;
  localparam int unsigned LenExt16 = 1;
  localparam int unsigned LenExt64 = 2;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  // Predictor state, mirrors the parser registers.
  rx_phase_e   rx_phase  = RX_HDR0;
  logic [3:0]  hdr_left  = '0;
  logic [63:0] body_left = '0;
  logic [31:0] key_word  = '0;
  logic [1:0]  key_pos   = '0;
  logic        key_on    = 1'b0;

  out_word_t   expected_words[$];
  logic [7:0]  chunk_bytes[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned bytes_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  websocket_frame_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial forever #1 clk_i = ~clk_i;

  // Give up on a hang: a lost word or a stuck handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("websocket_frame_deframer verification failed");
      $finish;
    end
  end

  // Stall the output side at the current idle rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Append one byte to the chunk under construction.
  function automatic void add_chunk_byte(input logic [7:0] b);
    chunk_bytes.insert(chunk_bytes.size(), b);
  endfunction

  // Work out the word (if any) that one accepted input byte causes, and
  // advance the predicted parser state.
  function automatic void predict_word(input in_word_t w);
    logic [7:0] key_byte;
    logic       hdr_done;
    logic       emitted;
    out_word_t  r;
    key_byte = '0;
    hdr_done = 1'b0;
    emitted  = 1'b0;
    r        = '0;
    case (rx_phase)
      RX_HDR0: begin
        // FIN and opcode carry no meaning here; skip the byte.
        rx_phase = RX_HDR1;
      end
      RX_HDR1: begin
        key_on    = ((w.rx_byte & MaskBit) != '0);
        key_word  = '0;
        key_pos   = '0;
        body_left = '0;
        if (w.rx_byte[6:0] == Len16Code) begin
          hdr_left = Ext16Cnt;
          rx_phase = RX_EXTLEN;
        end else if (w.rx_byte[6:0] == Len64Code) begin
          hdr_left = Ext64Cnt;
          rx_phase = RX_EXTLEN;
        end else begin
          body_left = 64'(w.rx_byte & Len7Mask);
          if (key_on) begin
            hdr_left = KeyCnt;
            rx_phase = RX_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      RX_EXTLEN: begin
        // Big-endian: shift the running length up and append.
        body_left = {body_left[55:0], w.rx_byte};
        hdr_left  = hdr_left - 1'b1;
        if (hdr_left == '0) begin
          if (key_on) begin
            hdr_left = KeyCnt;
            rx_phase = RX_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      RX_KEY: begin
        // First key byte ends up in the top byte of the key word.
        key_word = {key_word[23:0], w.rx_byte};
        hdr_left = hdr_left - 1'b1;
        if (hdr_left == '0) hdr_done = 1'b1;
      end
      RX_PAYLOAD: begin
        if (key_on) key_byte = key_word[31 - 8 * key_pos -: 8];
        key_pos        = key_pos + 1'b1;
        body_left      = body_left - 1'b1;
        r.payload_byte = w.rx_byte ^ key_byte;
        r.byte_valid   = 1'b1;
        if (body_left == '0) begin
          rx_phase    = RX_DRAIN;
          r.frame_end = 1'b1;
        end else begin
          // A chunk end inside the payload cuts the frame short.
          r.frame_end = w.chunk_end;
          r.status    = w.chunk_end;
        end
        emitted = 1'b1;
      end
      default: ;
    endcase

    if (hdr_done) rx_phase = (body_left == '0) ? RX_DRAIN : RX_PAYLOAD;

    if (hdr_done && body_left == '0) begin
      // Empty frame: mark its end with no byte.
      r.frame_end = 1'b1;
      emitted     = 1'b1;
    end else if (w.chunk_end && !emitted && rx_phase != RX_DRAIN) begin
      // Chunk ended on a header byte before the frame was complete.
      r.frame_end = 1'b1;
      r.status    = 1'b1;
      emitted     = 1'b1;
    end

    if (emitted) expected_words.insert(expected_words.size(), r);
    if (w.chunk_end) begin
      rx_phase = RX_HDR0;
      hdr_left = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Score every output word taken by the receiver against the oldest
  // prediction.
  always @(posedge clk_i) begin : score_words
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("word with none expected: payload_byte %h byte_valid %b frame_end %b status %b",
               out_word_o.payload_byte, out_word_o.byte_valid,
               out_word_o.frame_end, out_word_o.status);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("payload_byte", want.payload_byte, out_word_o.payload_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_word_o.byte_valid));
        check_field("frame_end", 8'(want.frame_end), 8'(out_word_o.frame_end));
        check_field("status", 8'(want.status), 8'(out_word_o.status));
      end
    end
  end

  // Send one byte: maybe idle first, then hold valid and the word until the
  // block takes it. Returns in the step of acceptance with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_word_t w;
    w.rx_byte   = b;
    w.chunk_end = last;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
    bytes_sent++;
  endtask

  // Build one frame into chunk_bytes: random first byte, length field in the
  // given form, optional key, then body_bytes of random payload.
  task automatic queue_frame(input logic masked, input int unsigned form,
                             input logic [63:0] len, input int unsigned body_bytes);
    chunk_bytes.delete();
    add_chunk_byte(8'($urandom_range(255)));
    case (form)
      LenShort: add_chunk_byte({masked, len[6:0]});
      LenExt16: begin
        add_chunk_byte({masked, Len16Code});
        add_chunk_byte(len[15:8]);
        add_chunk_byte(len[7:0]);
      end
      default: begin
        add_chunk_byte({masked, Len64Code});
        for (int i = 7; i >= 0; i--) add_chunk_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) add_chunk_byte(8'($urandom_range(255)));
    repeat (body_bytes) add_chunk_byte(8'($urandom_range(255)));
  endtask

  // Mostly small frames; a few long or huge ones, which get cut by the
  // chunk end. About one in five chunks ends early at a random point.
  task automatic send_random_frame();
    logic        masked;
    logic        few;
    int unsigned form;
    int unsigned pick;
    int unsigned body;
    int unsigned cut;
    logic [63:0] len;
    masked = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    few    = ($urandom_range(99) < 85);
    form   = (pick < 70) ? LenShort : (pick < 85) ? LenExt16 : LenExt64;
    case (form)
      LenShort: len = few ? 64'($urandom_range(12)) : 64'($urandom_range(125));
      LenExt16: len = few ? 64'($urandom_range(20)) : 64'($urandom_range(65535));
      default:  len = few ? 64'($urandom_range(20)) : {$urandom, $urandom};
    endcase
    body = (len > 40) ? $urandom_range(1, 24) : 32'(len);
    queue_frame(masked, form, len, body);
    // Add trailing bytes after complete frames; the block must drop them.
    if (len <= 40) repeat ($urandom_range(3)) add_chunk_byte(8'($urandom_range(255)));
    cut = ($urandom_range(99) < 80) ? chunk_bytes.size()
                                     : $urandom_range(1, chunk_bytes.size());
    for (int i = 0; i < cut; i++) send_byte(chunk_bytes[i], i == cut - 1);
  endtask

  // Zero-length frames, unmasked and masked, plus trailing bytes after one.
  task automatic test_empty_frames();
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h82, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Masked payload ending exactly on the chunk end.
  task automatic test_masked_payload();
    send_byte(8'h81, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  // Chunks that end early: on the first header byte, and inside the payload.
  task automatic test_short_chunks();
    send_byte(8'h81, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // Largest 64-bit length, counted down but never finished.
  task automatic test_huge_length();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // Mostly well-formed frames with random content, the rest noise.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        send_byte(8'($urandom_range(255)), 1'b1);
      end else begin
        send_random_frame();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 72;
    test_empty_frames();
    test_masked_payload();
    test_short_chunks();
    test_huge_length();
    test_random_traffic(500);

    send_idle_pct = 72;
    recv_idle_pct = 12;
    test_random_traffic(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(500);

    // Drop valid after the last word and let the output side drain.
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wsdf_pkg.sv
rtl/websocket_frame_deframer.sv
bench/tb.sv
